>>> design/csfp_pkg.sv
// Package for the crontab field parser: character codes, line phases, token flag bits,
// field ranges and the command and status types of the range walker.
// Depends on nothing; every design file imports it.
package csfp_pkg;

  localparam int unsigned FIELD_MASK_W = 60;
  localparam int unsigned NUM_FIELDS   = 5;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_HYPH  = 8'h2d;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] NUM_SAT  = 8'hff;

  localparam logic [1:0] PH_START   = 2'd0;
  localparam logic [1:0] PH_FIELDS  = 2'd1;
  localparam logic [1:0] PH_SCRIPT  = 2'd2;
  localparam logic [1:0] PH_COMMENT = 2'd3;

  localparam int unsigned TF_STAR  = 0;
  localparam int unsigned TF_HYPH  = 1;
  localparam int unsigned TF_SLASH = 2;
  localparam int unsigned TF_ITEM  = 3;
  localparam int unsigned TF_FIELD = 4;

  localparam logic [1:0] KIND_FIELD   = 2'd0;
  localparam logic [1:0] KIND_SCRIPT  = 2'd1;
  localparam logic [1:0] KIND_COMMENT = 2'd2;

  localparam logic [2:0] FLD_MINUTE  = 3'd0;
  localparam logic [2:0] FLD_HOUR    = 3'd1;
  localparam logic [2:0] FLD_DAY     = 3'd2;
  localparam logic [2:0] FLD_MONTH   = 3'd3;
  localparam logic [2:0] FLD_WEEKDAY = 3'd4;

  typedef struct packed {
    logic       start;
    logic [5:0] from_off;
    logic [5:0] to_off;
    logic [5:0] top_off;
    logic [7:0] step;
  } walk_cmd_t;

  typedef struct packed {
    logic       busy;
    logic       mark_vld;
    logic [5:0] mark_off;
  } walk_stat_t;

  function automatic logic [2:0] cur_field(input logic [2:0] fc);
    return (fc > FLD_WEEKDAY) ? FLD_WEEKDAY : fc;
  endfunction

  function automatic logic [7:0] fld_low(input logic [2:0] fi);
    logic [7:0] lo;
    case (fi)
      FLD_DAY, FLD_MONTH: lo = 8'd1;
      default:            lo = 8'd0;
    endcase
    return lo;
  endfunction

  function automatic logic [7:0] fld_high(input logic [2:0] fi);
    logic [7:0] hi;
    case (fi)
      FLD_MINUTE:  hi = 8'd59;
      FLD_HOUR:    hi = 8'd23;
      FLD_DAY:     hi = 8'd31;
      FLD_MONTH:   hi = 8'd12;
      FLD_WEEKDAY: hi = 8'd6;
      default:     hi = 8'd6;
    endcase
    return hi;
  endfunction

endpackage

>>> design/cron_schedule_field_parser.sv
// Top level of the crontab field parser: character sequencer, token state, output register.
// Depends on csfp_pkg and csfp_walker.
//
// Characters of a crontab line arrive one word at a time on the in_ channel (valid/ready),
// with in_end_of_line marking the last character. Results leave on the out_ channel: one
// bitmask word per schedule field, one word per script byte and one word for a comment line.
// in_ready is high only while the sequencer is idle, so one character is handled at a time.
// A plain digit or operator character, or a character after the '#' of a comment line,
// is handled in the accept step alone. A script byte or the '#' itself takes the accept
// step, then loading of the output register. A comma, or a space or end of line that
// closes a field, with an item pending takes the accept step, a setup step and a walk in
// the shared walker adder, which wraps once when the range runs past the field top; an
// item out of range skips the walk. Closing a field adds a step to load the field result.
// If the receiver stalls, the finished word is held in the output register and the
// sequencer waits before loading the next result; characters that give no result are
// still taken meanwhile. Synchronous reset puts the line at its start with empty token
// and mask state and the output register empty.
module cron_schedule_field_parser #(
  parameter int unsigned MASK_WIDTH = 60
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  input  logic        in_end_of_line,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [2:0]  out_field_index,
  output logic [59:0] out_field_mask,
  output logic [7:0]  out_script_byte,
  output logic        out_bad_value,
  output logic        out_last
);
  import csfp_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_CLOSE = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [1:0]            phase_r, phase_nxt;
  logic [2:0]            fc_r, fc_nxt;
  logic [7:0]            num_r, num_nxt;
  logic [7:0]            rs_r, rs_nxt;
  logic [7:0]            re_r, re_nxt;
  logic [4:0]            tf_r, tf_nxt;
  logic [MASK_WIDTH-1:0] mask_r, mask_nxt;
  logic                  err_r, err_nxt;
  logic [7:0]            c_r, c_nxt;
  logic                  eol_r, eol_nxt;
  logic                  close_r, close_nxt;
  logic                  extra_r, extra_nxt;
  logic [1:0]            pend_r, pend_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            out_kind_r, out_kind_nxt;
  logic [2:0]            out_idx_r, out_idx_nxt;
  logic [59:0]           out_mask_r, out_mask_nxt;
  logic [7:0]            out_byte_r, out_byte_nxt;
  logic                  out_bad_r, out_bad_nxt;
  logic                  out_last_r, out_last_nxt;

  walk_cmd_t             wcmd;
  walk_stat_t            wstat;

  logic                  out_free;
  logic                  line_rst;
  logic [2:0]            fi;
  logic [7:0]            lo, hi;
  logic [7:0]            rs_eff, re_eff, from_v, to_v, step_v;
  logic                  bad_rng;
  logic [11:0]           dig_sum;
  logic                  field_after;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = state_r == S_IDLE;
  assign fi       = cur_field(fc_r);
  assign lo       = fld_low(fi);
  assign hi       = fld_high(fi);
  assign dig_sum  = {1'b0, num_r, 3'b000} + {3'b000, num_r, 1'b0} + {4'b0000, in_ch - CH_0};

  always_comb begin
    rs_eff = (tf_r[TF_SLASH] || tf_r[TF_HYPH]) ? rs_r : num_r;
    re_eff = (tf_r[TF_HYPH] && !tf_r[TF_SLASH]) ? num_r : re_r;
    step_v = (!tf_r[TF_SLASH] || num_r == 8'd0) ? 8'd1 : num_r;
    if (tf_r[TF_STAR]) begin
      from_v = lo;
      to_v   = hi;
    end else if (tf_r[TF_HYPH]) begin
      from_v = rs_eff;
      to_v   = re_eff;
    end else begin
      from_v = rs_eff;
      to_v   = rs_eff;
    end
    bad_rng = from_v < lo || from_v > hi || to_v < lo || to_v > hi;
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    fc_nxt    = fc_r;
    num_nxt   = num_r;
    rs_nxt    = rs_r;
    re_nxt    = re_r;
    tf_nxt    = tf_r;
    mask_nxt  = mask_r;
    err_nxt   = err_r;
    c_nxt     = c_r;
    eol_nxt   = eol_r;
    close_nxt = close_r;
    extra_nxt = extra_r;
    pend_nxt  = pend_r;
    line_rst  = 1'b0;
    field_after = tf_r[TF_FIELD];

    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_idx_nxt   = out_idx_r;
    out_mask_nxt  = out_mask_r;
    out_byte_nxt  = out_byte_r;
    out_bad_nxt   = out_bad_r;
    out_last_nxt  = out_last_r;

    wcmd.start    = 1'b0;
    wcmd.from_off = 6'(from_v - lo);
    wcmd.to_off   = 6'(to_v - lo);
    wcmd.top_off  = 6'(hi - lo);
    wcmd.step     = step_v;

    if (wstat.mark_vld) begin
      mask_nxt = mask_r | ({{(MASK_WIDTH-1){1'b0}}, 1'b1} << wstat.mark_off);
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          c_nxt   = in_ch;
          eol_nxt = in_end_of_line;
          case (phase_r)
            PH_COMMENT: begin
              line_rst = in_end_of_line;
            end
            PH_SCRIPT: begin
              pend_nxt  = KIND_SCRIPT;
              state_nxt = S_EMIT;
              line_rst  = in_end_of_line;
            end
            default: begin
              if (phase_r == PH_START && in_ch == CH_HASH) begin
                pend_nxt  = KIND_COMMENT;
                state_nxt = S_EMIT;
                phase_nxt = in_end_of_line ? PH_START : PH_COMMENT;
              end else begin
                phase_nxt = PH_FIELDS;
                if (in_ch == CH_SPACE || in_ch == CH_COMMA) begin
                  field_after = tf_r[TF_FIELD];
                end else begin
                  field_after = 1'b1;
                  tf_nxt[TF_FIELD] = 1'b1;
                  if (in_ch inside {[CH_0:CH_9]}) begin
                    num_nxt = (dig_sum > {4'b0000, NUM_SAT}) ? NUM_SAT : dig_sum[7:0];
                    tf_nxt[TF_ITEM] = 1'b1;
                  end else if (in_ch == CH_STAR) begin
                    tf_nxt[TF_STAR] = 1'b1;
                    tf_nxt[TF_ITEM] = 1'b1;
                  end else if (in_ch == CH_HYPH) begin
                    if (tf_r[TF_HYPH] || tf_r[TF_SLASH]) begin
                      err_nxt = 1'b1;
                    end else begin
                      rs_nxt  = num_r;
                      num_nxt = 8'd0;
                      tf_nxt[TF_HYPH] = 1'b1;
                    end
                    tf_nxt[TF_ITEM] = 1'b1;
                  end else if (in_ch == CH_SLASH) begin
                    if (tf_r[TF_SLASH]) begin
                      err_nxt = 1'b1;
                    end else begin
                      if (tf_r[TF_HYPH]) begin
                        re_nxt = num_r;
                      end else begin
                        rs_nxt = num_r;
                      end
                      num_nxt = 8'd0;
                      tf_nxt[TF_SLASH] = 1'b1;
                    end
                    tf_nxt[TF_ITEM] = 1'b1;
                  end else begin
                    err_nxt = 1'b1;
                  end
                end
                close_nxt = in_end_of_line || (in_ch == CH_SPACE && tf_r[TF_FIELD]);
                extra_nxt = in_end_of_line && (fc_r < FLD_WEEKDAY || !field_after);
                if ((in_ch == CH_COMMA || close_nxt) && tf_nxt[TF_ITEM]) begin
                  state_nxt = S_SETUP;
                end else if (close_nxt) begin
                  state_nxt = S_CLOSE;
                end
              end
            end
          endcase
        end
      end
      S_SETUP: begin
        if (bad_rng) begin
          err_nxt   = 1'b1;
          state_nxt = close_r ? S_CLOSE : S_IDLE;
        end else begin
          wcmd.start = 1'b1;
          state_nxt  = S_WALK;
        end
        tf_nxt  = tf_r & (5'b00001 << TF_FIELD);
        num_nxt = 8'd0;
        rs_nxt  = 8'd0;
        re_nxt  = 8'd0;
      end
      S_WALK: begin
        if (!wstat.busy) begin
          state_nxt = close_r ? S_CLOSE : S_IDLE;
        end
      end
      S_CLOSE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_FIELD;
          out_idx_nxt   = fi;
          out_mask_nxt  = mask_r[FIELD_MASK_W-1:0];
          out_byte_nxt  = 8'd0;
          out_bad_nxt   = err_r || extra_r;
          out_last_nxt  = eol_r;
          mask_nxt      = '0;
          err_nxt       = 1'b0;
          tf_nxt        = '0;
          num_nxt       = 8'd0;
          if (fc_r >= FLD_WEEKDAY) begin
            phase_nxt = PH_SCRIPT;
          end else begin
            fc_nxt = fc_r + 3'd1;
          end
          line_rst  = eol_r;
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = pend_r;
          out_idx_nxt   = FLD_MINUTE;
          out_mask_nxt  = '0;
          out_byte_nxt  = (pend_r == KIND_SCRIPT) ? c_r : 8'd0;
          out_bad_nxt   = 1'b0;
          out_last_nxt  = (pend_r == KIND_COMMENT) ? 1'b1 : eol_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (line_rst) begin
      phase_nxt = PH_START;
      fc_nxt    = '0;
      num_nxt   = 8'd0;
      rs_nxt    = 8'd0;
      re_nxt    = 8'd0;
      tf_nxt    = '0;
      mask_nxt  = '0;
      err_nxt   = 1'b0;
    end
  end

  csfp_walker u_walker (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (wcmd),
    .stat  (wstat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_START;
      fc_r        <= '0;
      num_r       <= 8'd0;
      rs_r        <= 8'd0;
      re_r        <= 8'd0;
      tf_r        <= '0;
      mask_r      <= '0;
      err_r       <= 1'b0;
      close_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      fc_r        <= fc_nxt;
      num_r       <= num_nxt;
      rs_r        <= rs_nxt;
      re_r        <= re_nxt;
      tf_r        <= tf_nxt;
      mask_r      <= mask_nxt;
      err_r       <= err_nxt;
      close_r     <= close_nxt;
      out_valid_r <= out_valid_nxt;
    end
    c_r        <= c_nxt;
    eol_r      <= eol_nxt;
    extra_r    <= extra_nxt;
    pend_r     <= pend_nxt;
    out_kind_r <= out_kind_nxt;
    out_idx_r  <= out_idx_nxt;
    out_mask_r <= out_mask_nxt;
    out_byte_r <= out_byte_nxt;
    out_bad_r  <= out_bad_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_field_index = out_idx_r;
  assign out_field_mask  = out_mask_r;
  assign out_script_byte = out_byte_r;
  assign out_bad_value   = out_bad_r;
  assign out_last        = out_last_r;

  // The walker only runs while the sequencer waits on it.
  a_walk_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    wstat.busy |-> state_r == S_WALK)
    else $error("walker busy outside the walk state");

  a_mark_in_field: assert property (@(posedge clk) disable iff (!rst_n)
    wstat.mark_vld |-> wstat.mark_off <= 6'(hi - lo))
    else $error("walker marked a bit beyond the field top");

  a_comment_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_COMMENT |-> out_last_r)
    else $error("comment word without last");

  a_plain_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r != KIND_FIELD |-> out_mask_r == '0 && !out_bad_r)
    else $error("script or comment word carries a mask or error");

  a_field_count: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= FLD_WEEKDAY)
    else $error("field counter beyond the weekday field");

endmodule

>>> design/csfp_walker.sv
// Range walker for the crontab field parser: one shared nine-bit adder steps an offset
// through a range, wrapping once past the field top; while in range it reports one bit to set per cycle.
// Depends on csfp_pkg.
module csfp_walker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  csfp_pkg::walk_cmd_t  cmd,
  output csfp_pkg::walk_stat_t stat
);
  import csfp_pkg::*;

  logic       busy_r, busy_nxt;
  logic       wrap_r, wrap_nxt;
  logic [8:0] pos_r, pos_nxt;
  logic [5:0] lim_r, lim_nxt;
  logic [5:0] to_r, to_nxt;
  logic [5:0] top_r, top_nxt;
  logic [7:0] step_r, step_nxt;
  logic       in_range;
  logic [8:0] addend;
  logic [8:0] span;

  assign span     = {3'b000, top_r} + 9'd1;
  assign in_range = pos_r <= {3'b000, lim_r};
  assign addend   = in_range ? {1'b0, step_r} : (9'd0 - span);

  assign stat = '{busy: busy_r, mark_vld: busy_r && in_range, mark_off: pos_r[5:0]};

  always_comb begin
    busy_nxt = busy_r;
    wrap_nxt = wrap_r;
    pos_nxt  = pos_r;
    lim_nxt  = lim_r;
    to_nxt   = to_r;
    top_nxt  = top_r;
    step_nxt = step_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      pos_nxt  = {3'b000, cmd.from_off};
      wrap_nxt = cmd.from_off > cmd.to_off;
      lim_nxt  = (cmd.from_off > cmd.to_off) ? cmd.top_off : cmd.to_off;
      to_nxt   = cmd.to_off;
      top_nxt  = cmd.top_off;
      step_nxt = cmd.step;
    end else if (busy_r) begin
      if (in_range) begin
        pos_nxt = pos_r + addend;
      end else if (wrap_r) begin
        pos_nxt  = pos_r + addend;
        wrap_nxt = 1'b0;
        lim_nxt  = to_r;
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      wrap_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      wrap_r <= wrap_nxt;
    end
    pos_r  <= pos_nxt;
    lim_r  <= lim_nxt;
    to_r   <= to_nxt;
    top_r  <= top_nxt;
    step_r <= step_nxt;
  end

endmodule

>>> tb/sv/csfp_sched_checker.sv
// Checker for the crontab field parser: watches both channels, predicts every result word
// from the accepted characters and compares the words that leave the block.
// Depends on csfp_pkg for character codes, phases, token flag bits, kinds and field indexes.
module csfp_sched_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_ch,
  input  logic        in_end_of_line,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_kind,
  input  logic [2:0]  out_field_index,
  input  logic [59:0] out_field_mask,
  input  logic [7:0]  out_script_byte,
  input  logic        out_bad_value,
  input  logic        out_last,
  output int          fail_count,
  output int          words_pending,
  output int          words_checked
);
  import csfp_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  field_index;
    logic [59:0] field_mask;
    logic [7:0]  script_byte;
    logic        bad_value;
    logic        last;
  } sched_word_t;

  localparam logic [63:0] KEEP_BITS = (64'd1 << FIELD_MASK_W) - 64'd1;

  sched_word_t expected_words[$];

  logic [2:0]  fld_cnt;
  logic [7:0]  num_acc;
  logic [7:0]  rng_lo;
  logic [7:0]  rng_hi;
  logic [7:0]  step_val;
  logic [4:0]  tok;
  logic [63:0] mask_acc;
  logic [1:0]  phase;
  logic        err;

  function automatic int unsigned range_min(input logic [2:0] fi);
    return (fi == FLD_DAY || fi == FLD_MONTH) ? 1 : 0;
  endfunction

  function automatic int unsigned range_max(input logic [2:0] fi);
    case (fi)
      FLD_MINUTE: return 59;
      FLD_HOUR:   return 23;
      FLD_DAY:    return 31;
      FLD_MONTH:  return 12;
      default:    return 6;
    endcase
  endfunction

  function automatic sched_word_t make_word(input logic [1:0] kind, input logic [2:0] fi,
                                            input logic [59:0] mask, input logic [7:0] sb,
                                            input logic bad, input logic last);
    sched_word_t w;
    w.kind        = kind;
    w.field_index = fi;
    w.field_mask  = mask;
    w.script_byte = sb;
    w.bad_value   = bad;
    w.last        = last;
    return w;
  endfunction

  task automatic clear_line();
    fld_cnt  = '0;
    num_acc  = '0;
    rng_lo   = '0;
    rng_hi   = '0;
    step_val = '0;
    tok      = '0;
    mask_acc = '0;
    phase    = PH_START;
    err      = 1'b0;
  endtask

  task automatic set_bit(input int unsigned off);
    mask_acc = (mask_acc | (64'd1 << (off & 63))) & KEEP_BITS;
  endtask

  task automatic finish_item();
    logic [2:0]  fi;
    int unsigned lo, hi, from, to, stp, v, span;
    if (!tok[TF_ITEM]) return;
    fi = (fld_cnt > FLD_WEEKDAY) ? FLD_WEEKDAY : fld_cnt;
    lo = range_min(fi);
    hi = range_max(fi);
    if (tok[TF_SLASH]) step_val = num_acc;
    else if (tok[TF_HYPH]) rng_hi = num_acc;
    else rng_lo = num_acc;
    stp = tok[TF_SLASH] ? step_val : 1;
    if (stp == 0) stp = 1;
    if (tok[TF_STAR]) begin
      from = lo;
      to   = hi;
    end else if (tok[TF_HYPH]) begin
      from = rng_lo;
      to   = rng_hi;
    end else begin
      from = rng_lo;
      to   = rng_lo;
    end
    if (from < lo || from > hi || to < lo || to > hi) begin
      err = 1'b1;
    end else if (from <= to) begin
      for (v = from; v <= to; v += stp) set_bit(v - lo);
    end else begin
      span = hi - lo + 1;
      for (v = from; v <= hi; v += stp) set_bit(v - lo);
      for (v = v - span; v <= to; v += stp) set_bit(v - lo);
    end
    tok     = tok & (5'd1 << TF_FIELD);
    num_acc = '0;
    rng_lo  = '0;
    rng_hi  = '0;
  endtask

  task automatic close_field(input logic last, input logic extra_bad);
    logic [2:0] fi;
    finish_item();
    fi = (fld_cnt > FLD_WEEKDAY) ? FLD_WEEKDAY : fld_cnt;
    expected_words.push_back(make_word(KIND_FIELD, fi, mask_acc[59:0], 8'h00,
                                       err | extra_bad, last));
    mask_acc = '0;
    err      = 1'b0;
    tok      = '0;
    num_acc  = '0;
    step_val = '0;
    if (fld_cnt >= FLD_WEEKDAY) phase = PH_SCRIPT;
    else fld_cnt = fld_cnt + 3'd1;
  endtask

  task automatic field_char(input logic [7:0] c);
    int unsigned n;
    if (c >= CH_0 && c <= CH_9) begin
      n = num_acc * 10 + (c - CH_0);
      num_acc = (n > 255) ? NUM_SAT : n[7:0];
      tok[TF_ITEM]  = 1'b1;
      tok[TF_FIELD] = 1'b1;
    end else if (c == CH_STAR) begin
      tok[TF_STAR]  = 1'b1;
      tok[TF_ITEM]  = 1'b1;
      tok[TF_FIELD] = 1'b1;
    end else if (c == CH_HYPH) begin
      if (tok[TF_HYPH] || tok[TF_SLASH]) begin
        err = 1'b1;
      end else begin
        rng_lo = num_acc;
        num_acc = '0;
        tok[TF_HYPH] = 1'b1;
      end
      tok[TF_ITEM]  = 1'b1;
      tok[TF_FIELD] = 1'b1;
    end else if (c == CH_SLASH) begin
      if (tok[TF_SLASH]) begin
        err = 1'b1;
      end else begin
        if (tok[TF_HYPH]) rng_hi = num_acc;
        else rng_lo = num_acc;
        num_acc = '0;
        tok[TF_SLASH] = 1'b1;
      end
      tok[TF_ITEM]  = 1'b1;
      tok[TF_FIELD] = 1'b1;
    end else if (c == CH_COMMA) begin
      finish_item();
    end else begin
      err = 1'b1;
      tok[TF_FIELD] = 1'b1;
    end
  endtask

  task automatic parse_char(input logic [7:0] c, input logic eol);
    logic       made;
    logic [2:0] fc;
    made = 1'b0;
    if (phase == PH_COMMENT) begin
      if (eol) clear_line();
      return;
    end
    if (phase == PH_SCRIPT) begin
      expected_words.push_back(make_word(KIND_SCRIPT, FLD_MINUTE, '0, c, 1'b0, eol));
      if (eol) clear_line();
      return;
    end
    if (phase == PH_START) begin
      if (c == CH_HASH) begin
        expected_words.push_back(make_word(KIND_COMMENT, FLD_MINUTE, '0, 8'h00, 1'b0, 1'b1));
        if (eol) clear_line();
        else phase = PH_COMMENT;
        return;
      end
      phase = PH_FIELDS;
    end
    fc = fld_cnt;
    if (c == CH_SPACE) begin
      if (tok[TF_FIELD]) begin
        close_field(eol, eol && fc < FLD_WEEKDAY);
        made = 1'b1;
      end
    end else begin
      field_char(c);
    end
    if (eol) begin
      if (!made) close_field(1'b1, fc < FLD_WEEKDAY || !tok[TF_FIELD]);
      clear_line();
    end
  endtask

  initial begin
    clear_line();
    fail_count    = 0;
    words_pending = 0;
    words_checked = 0;
  end

  always @(posedge clk) begin : watch
    sched_word_t got, exp_w;
    got = make_word(out_kind, out_field_index, out_field_mask, out_script_byte,
                    out_bad_value, out_last);
    if (!rst_n) begin
      clear_line();
      expected_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        words_checked++;
        if (expected_words.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected word: kind=%0d field=%0d mask=%h byte=%h bad=%b last=%b",
                     got.kind, got.field_index, got.field_mask, got.script_byte,
                     got.bad_value, got.last);
          fail_count++;
        end else begin
          exp_w = expected_words.pop_front();
          if (got !== exp_w) begin
            if (fail_count < 10) begin
              $display("mismatch, expected: kind=%0d field=%0d mask=%h byte=%h bad=%b last=%b",
                       exp_w.kind, exp_w.field_index, exp_w.field_mask, exp_w.script_byte,
                       exp_w.bad_value, exp_w.last);
              $display("               got: kind=%0d field=%0d mask=%h byte=%h bad=%b last=%b",
                       got.kind, got.field_index, got.field_mask, got.script_byte,
                       got.bad_value, got.last);
            end
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) parse_char(in_ch, in_end_of_line);
    end
    words_pending = expected_words.size();
  end

endmodule

>>> tb/sv/cron_schedule_field_parser_tb.sv
// Top of the crontab field parser testbench: clock, reset, character stimulus, receiver
// stalls and the verdict. Depends on csfp_pkg, the parser itself and csfp_sched_checker.
module cron_schedule_field_parser_tb;
  import csfp_pkg::*;

  localparam int CHAR_TARGET = 1900;
  localparam int CYCLE_LIMIT = 1000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_ch;
  logic        in_end_of_line;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic [2:0]  out_field_index;
  logic [59:0] out_field_mask;
  logic [7:0]  out_script_byte;
  logic        out_bad_value;
  logic        out_last;

  int fail_count;
  int words_pending;
  int words_checked;
  int cycles;
  int chars_sent;
  int lines_sent;
  bit tx_calm;
  bit rx_calm;

  logic [7:0] line_buf[$];

  cron_schedule_field_parser dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_ch           (in_ch),
    .in_end_of_line  (in_end_of_line),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_field_index (out_field_index),
    .out_field_mask  (out_field_mask),
    .out_script_byte (out_script_byte),
    .out_bad_value   (out_bad_value),
    .out_last        (out_last)
  );

  csfp_sched_checker sched_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_ch           (in_ch),
    .in_end_of_line  (in_end_of_line),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_field_index (out_field_index),
    .out_field_mask  (out_field_mask),
    .out_script_byte (out_script_byte),
    .out_bad_value   (out_bad_value),
    .out_last        (out_last),
    .fail_count      (fail_count),
    .words_pending   (words_pending),
    .words_checked   (words_checked)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(negedge clk) out_ready <= rx_calm || ($urandom_range(99) >= 9);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int unsigned field_top(input int fi);
    case (fi)
      FLD_MINUTE: return 59;
      FLD_HOUR:   return 23;
      FLD_DAY:    return 31;
      FLD_MONTH:  return 12;
      default:    return 6;
    endcase
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic add_num(input int unsigned v);
    add_text($sformatf("%0d", v));
  endtask

  function automatic int unsigned pick_value(input int fi);
    int unsigned lo, r;
    lo = (fi == FLD_DAY || fi == FLD_MONTH) ? 1 : 0;
    r  = $urandom_range(11);
    if (r == 0) return $urandom_range(255);
    if (r == 1) return (lo > 0 && $urandom_range(1) == 0) ? 0 : field_top(fi) + 1;
    return $urandom_range(field_top(fi), lo);
  endfunction

  task automatic add_item(input int fi);
    int unsigned r;
    r = $urandom_range(9);
    if (r < 2) begin
      add_text("*");
      if (r == 0 && $urandom_range(3) == 0) add_num(pick_value(fi));
    end else if (r < 6) begin
      add_num(pick_value(fi));
    end else begin
      add_num(pick_value(fi));
      add_text("-");
      add_num(pick_value(fi));
    end
    if ($urandom_range(2) == 0) begin
      add_text("/");
      if ($urandom_range(4) != 0) add_num($urandom_range(field_top(fi)));
    end
  endtask

  task automatic add_field(input int fi);
    int n;
    n = $urandom_range(3, 1);
    for (int k = 0; k < n; k++) begin
      if (k > 0) add_text(",");
      if ($urandom_range(9) == 0) add_text(",");
      add_item(fi);
    end
  endtask

  task automatic build_schedule_line();
    int nf, sl;
    if ($urandom_range(7) == 0) add_text(" ");
    nf = ($urandom_range(5) == 0) ? $urandom_range(4, 1) : 5;
    for (int f = 0; f < nf; f++) begin
      if (f > 0) add_text(($urandom_range(5) == 0) ? "  " : " ");
      add_field(f);
    end
    if (nf < 5) begin
      if ($urandom_range(1) == 0) add_text(" ");
    end else begin
      sl = $urandom_range(9) - 1;
      if (sl >= 0) begin
        add_text(" ");
        for (int i = 0; i < sl; i++) line_buf.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic build_noise_line();
    string ops;
    int n;
    ops = "*-/, 0123456789";
    n = $urandom_range(12, 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) line_buf.push_back(8'($urandom_range(255)));
      else line_buf.push_back(ops[$urandom_range(ops.len() - 1)]);
    end
  endtask

  task automatic send_char(input logic [7:0] c, input logic eol);
    while (!tx_calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_ch          <= c;
    in_end_of_line <= eol;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) send_char(line_buf[i], i == line_buf.size() - 1);
    lines_sent++;
    line_buf.delete();
  endtask

  initial begin
    int unsigned pick;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_ch          = 8'h00;
    in_end_of_line = 1'b0;
    tx_calm        = 1'b0;
    rx_calm        = 1'b0;
    chars_sent     = 0;
    lines_sent     = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_text("#");
    send_line();
    add_text(" 7-3/0,,*5 1-2-3 x 999 -/  z");
    send_line();
    add_text("1 2");
    send_line();
    add_text("#ab");
    send_line();

    while (chars_sent < CHAR_TARGET) begin
      tx_calm = (chars_sent >= 700 && chars_sent < 1000);
      rx_calm = tx_calm;
      pick = $urandom_range(19);
      if (pick < 2) begin
        add_text("#");
        repeat ($urandom_range(6)) line_buf.push_back(8'($urandom_range(255)));
      end else if (pick < 5) begin
        build_noise_line();
      end else begin
        build_schedule_line();
      end
      send_line();
    end
    in_valid <= 1'b0;

    while (words_pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("Sent %0d characters over %0d lines (comments, schedules, noise).",
             chars_sent, lines_sent);
    $display("Checked %0d result words in %0d cycles.", words_checked, cycles);
    if (fail_count == 0 && words_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures, %0d words outstanding", fail_count, words_pending);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
